// ===== design/can_frame_serializer_macros.svh =====
// Assertion macros shared by the CAN frame serializer RTL.
// No dependencies; included by the top level.
`ifndef CAN_FRAME_SERIALIZER_MACROS_SVH
`define CAN_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfs assertion failed");

`endif

// ===== design/cfs_pkg.sv =====
// Package for the CAN frame serializer: beat types, frame constants, internal structs.
// No dependencies.
`default_nettype none

package cfs_pkg;

  localparam int unsigned CHUNK_BITS   = 8;   // frame bits per output chunk
  localparam int unsigned STD_HDR_BITS = 19;  // SOF .. DLC, standard frame
  localparam int unsigned EXT_HDR_BITS = 39;  // SOF .. DLC, extended frame
  localparam int unsigned CRC_BITS     = 15;
  localparam int unsigned TAIL_BITS    = 10;  // CRC delim, ACK slot, ACK delim, EOF
  localparam int unsigned SHIFT_BITS   = 103; // longest header plus payload
  localparam logic [14:0] CRC_POLY     = 15'h4599;

  typedef struct packed {
    logic [28:0] identifier;
    logic        extended_format;
    logic        data_frame;
    logic [3:0]  length_code;
    logic [63:0] payload_bits;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] chunk;
    logic [3:0] valid_bits;
    logic       last_chunk;
    logic [7:0] frame_length;
  } out_beat_t;

  // One frame bit handed from the sequencer to the packer.
  typedef struct packed {
    logic       vld;
    logic       value;
    logic       last;
    logic [7:0] frame_len;
  } bit_beat_t;

  // Control of the bit-serial CRC unit.
  typedef struct packed {
    logic clr;
    logic shift_in;
    logic shift_out;
    logic din;
  } crc_ctl_t;

endpackage

`default_nettype wire

// ===== design/cfs_crc15.sv =====
// Bit-serial CRC-15 register: accumulates frame bits, then shifts the remainder out MSB first.
// Depends on cfs_pkg.
`default_nettype none

module cfs_crc15
  import cfs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire crc_ctl_t ctl_i,
  output logic          msb_o
);

  logic [14:0] crc_q, crc_d;
  logic        fb;

  always_comb begin
    fb    = ctl_i.din ^ crc_q[14];
    crc_d = crc_q;
    if (ctl_i.clr) begin
      crc_d = '0;
    end else if (ctl_i.shift_in) begin
      crc_d = {crc_q[13:0], 1'b0} ^ (fb ? CRC_POLY : 15'h0000);
    end else if (ctl_i.shift_out) begin
      crc_d = {crc_q[13:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign msb_o = crc_q[14];

endmodule

`default_nettype wire

// ===== design/cfs_packer.sv =====
// Chunk packer: collects frame bits into chunks and holds each chunk in an output register.
// Depends on cfs_pkg.
`default_nettype none

module cfs_packer
  import cfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bit_beat_t bit_i,
  output logic           bit_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned FW = $clog2(CHUNK_BITS + 1);

  logic [CHUNK_BITS-1:0] acc_q, word;
  logic [FW-1:0]         fill_q, fill_inc;
  logic                  out_vld_q;
  out_beat_t             out_q;
  logic                  emit, take;
  logic [CHUNK_BITS+7:0] word_wide;
  logic [FW+3:0]         vb_wide;

  always_comb begin
    for (int k = 0; k < CHUNK_BITS; k++) begin
      word[k] = acc_q[k] | (bit_i.value && (fill_q == FW'(CHUNK_BITS - 1 - k)));
    end
  end

  assign fill_inc    = fill_q + FW'(1);
  assign emit        = bit_i.vld && ((fill_q == FW'(CHUNK_BITS - 1)) || bit_i.last);
  assign bit_ready_o = !emit || !out_vld_q || out_ready_i;
  assign take        = bit_i.vld && bit_ready_o;
  assign word_wide   = {8'h00, word};
  assign vb_wide     = {4'h0, fill_inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (take) begin
        if (emit) begin
          acc_q  <= '0;
          fill_q <= '0;
        end else begin
          acc_q  <= word;
          fill_q <= fill_inc;
        end
      end
    end
  end

  // Payload of the output register carries no reset.
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q.chunk        <= word_wide[7:0];
      out_q.valid_bits   <= vb_wide[3:0];
      out_q.last_chunk   <= bit_i.last;
      out_q.frame_length <= bit_i.last ? bit_i.frame_len : 8'h00;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/can_frame_serializer.sv =====
// Timing: a frame is accepted while idle, then one frame bit per cycle (44 to 128) unless the
// sink stalls the packer, set by the bit-serial CRC and shift register; the last chunk is valid
// in the cycle after its last bit. The next frame is accepted only after the last bit is sent.
// Reset: rst_ni asynchronous, active low; clears sequencer, CRC, packer fill and output valid.
`default_nettype none

`include "can_frame_serializer_macros.svh"

module can_frame_serializer
  import cfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  localparam logic [3:0] VB_FULL = 4'(CHUNK_BITS);

  state_e                state_q;
  logic [SHIFT_BITS-1:0] sh_q, sh_d;
  logic [7:0]            pos_q, pre_len_q, crc_end_q, total_q;
  logic [6:0]            pre_len_d;
  logic [3:0]            nbytes;
  logic [10:0]           base_id;
  logic                  rtr;
  logic                  in_body, in_crc, bit_ready, advance, crc_msb;
  bit_beat_t             beat;
  crc_ctl_t              crc_ctl;

  assign in_ready_o = (state_q == ST_IDLE);

  // Build the header and payload image of a new frame.
  always_comb begin
    base_id = in_data_i.identifier[28:18];
    rtr     = !in_data_i.data_frame;
    if (!in_data_i.data_frame) begin
      nbytes = 4'd0;
    end else if (in_data_i.length_code > 4'd8) begin
      nbytes = 4'd8;
    end else begin
      nbytes = in_data_i.length_code;
    end
    if (in_data_i.extended_format) begin
      sh_d = {1'b0, base_id, 1'b1, 1'b1, in_data_i.identifier[17:0], rtr, 2'b00,
              in_data_i.length_code, in_data_i.payload_bits};
      pre_len_d = 7'(EXT_HDR_BITS) + {nbytes, 3'b000};
    end else begin
      sh_d = {1'b0, base_id, rtr, 1'b0, 1'b0, in_data_i.length_code,
              in_data_i.payload_bits, 20'h00000};
      pre_len_d = 7'(STD_HDR_BITS) + {nbytes, 3'b000};
    end
  end

  assign in_body = (pos_q < pre_len_q);
  assign in_crc  = !in_body && (pos_q < crc_end_q);
  assign advance = (state_q == ST_RUN) && bit_ready;

  always_comb begin
    beat.vld       = (state_q == ST_RUN);
    beat.value     = in_body ? sh_q[SHIFT_BITS-1] : (in_crc ? crc_msb : 1'b1);
    beat.last      = (pos_q == total_q - 8'd1);
    beat.frame_len = total_q;

    crc_ctl.clr       = in_valid_i && in_ready_o;
    crc_ctl.shift_in  = advance && in_body;
    crc_ctl.shift_out = advance && in_crc;
    crc_ctl.din       = sh_q[SHIFT_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sh_q      <= '0;
      pos_q     <= '0;
      pre_len_q <= '0;
      crc_end_q <= '0;
      total_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sh_q      <= sh_d;
            pos_q     <= '0;
            pre_len_q <= {1'b0, pre_len_d};
            crc_end_q <= {1'b0, pre_len_d} + 8'(CRC_BITS);
            total_q   <= {1'b0, pre_len_d} + 8'(CRC_BITS + TAIL_BITS);
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            pos_q <= pos_q + 8'd1;
            sh_q  <= {sh_q[SHIFT_BITS-2:0], 1'b0};
            if (beat.last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  cfs_crc15 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .msb_o  (crc_msb)
  );

  cfs_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_i       (beat),
    .bit_ready_o (bit_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `CFS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CFS_ASSERT_NOW(a_last_len_range, clk_i, rst_ni, out_valid_o && out_data_o.last_chunk,
                  (out_data_o.frame_length >= 8'd44) && (out_data_o.frame_length <= 8'd128))
  `CFS_ASSERT_NOW(a_mid_len_zero, clk_i, rst_ni, out_valid_o && !out_data_o.last_chunk,
                  out_data_o.frame_length == 8'd0)
  `CFS_ASSERT_NOW(a_mid_chunk_full, clk_i, rst_ni, out_valid_o && !out_data_o.last_chunk,
                  out_data_o.valid_bits == VB_FULL)

endmodule

`default_nettype wire

// ===== dv/tb_can_frame_serializer.sv =====
// Self-checking testbench for can_frame_serializer: frame requests go in, and each 8-bit
// chunk that comes out is compared with a chunk list predicted from the CAN 2.0 frame layout.
// Depends on cfs_pkg (beat types, CRC polynomial) and the can_frame_serializer RTL.
module tb_can_frame_serializer;
  import cfs_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  out_beat_t expected_chunks[$];
  int        mismatch_count    = 0;
  int        idle_cycles       = 0;
  int        burst_left        = 0;
  bit        sender_steady     = 1'b0;
  bit        sink_always_ready = 1'b0;
  int        sink_run          = 0;

  can_frame_serializer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Build the unstuffed bit sequence of one frame and queue its chunks.
  function automatic void predict_frame_chunks(input in_beat_t f);
    logic [127:0] seq;
    logic [38:0]  hdr;
    logic [14:0]  crc;
    logic         rtr;
    logic         fb;
    int           hdr_len;
    int           len;
    int           nbytes;
    int           i;
    int           pos;
    int           nvalid;
    out_beat_t    beat;
    seq = '0;
    len = 0;
    rtr = ~f.data_frame;
    if (f.extended_format) begin
      hdr = {1'b0, f.identifier[28:18], 1'b1, 1'b1, f.identifier[17:0], rtr, 2'b00,
             f.length_code};
      hdr_len = 39;
    end else begin
      hdr = {20'd0, 1'b0, f.identifier[28:18], rtr, 1'b0, 1'b0, f.length_code};
      hdr_len = 19;
    end
    for (i = hdr_len - 1; i >= 0; i--) begin
      seq[127 - len] = hdr[i];
      len++;
    end
    // A length code above eight still carries eight bytes.
    nbytes = !f.data_frame ? 0 : (f.length_code > 4'd8 ? 8 : int'(f.length_code));
    for (i = 0; i < nbytes * 8; i++) begin
      seq[127 - len] = f.payload_bits[63 - i];
      len++;
    end
    crc = '0;
    for (i = 0; i < len; i++) begin
      fb  = seq[127 - i] ^ crc[14];
      crc = {crc[13:0], 1'b0};
      if (fb) crc = crc ^ CRC_POLY;
    end
    for (i = 14; i >= 0; i--) begin
      seq[127 - len] = crc[i];
      len++;
    end
    // CRC delimiter, ACK slot, ACK delimiter and EOF are all recessive.
    for (i = 0; i < 10; i++) begin
      seq[127 - len] = 1'b1;
      len++;
    end
    for (pos = 0; pos < len; pos += 8) begin
      nvalid            = (len - pos > 8) ? 8 : len - pos;
      beat.chunk        = seq[127 - pos -: 8];
      beat.valid_bits   = 4'(nvalid);
      beat.last_chunk   = (pos + 8 >= len);
      beat.frame_length = beat.last_chunk ? 8'(len) : 8'd0;
      expected_chunks.push_back(beat);
    end
  endfunction

  function automatic in_beat_t make_frame(input logic [28:0] id, input logic ext,
                                          input logic data, input logic [3:0] dlc,
                                          input logic [63:0] pay);
    in_beat_t f;
    f.identifier      = id;
    f.extended_format = ext;
    f.data_frame      = data;
    f.length_code     = dlc;
    f.payload_bits    = pay;
    return f;
  endfunction

  function automatic in_beat_t random_frame();
    logic [3:0] dlc;
    dlc = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    return make_frame(29'($urandom()), 1'($urandom()), ($urandom_range(0, 5) != 0), dlc,
                      {$urandom(), $urandom()});
  endfunction

  task automatic sender_idle(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_frame(input in_beat_t f);
    if (burst_left == 0) begin
      if (!sender_steady)
        sender_idle(($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 6);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame_chunks(f);
    burst_left--;
  endtask

  task automatic wait_drained();
    sender_idle(0);
    while (expected_chunks.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_frame(make_frame(29'h0, 1'b0, 1'b1, 4'd0, 64'h0));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b0, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h0, 1'b1, 1'b1, 4'd8, 64'h0));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h1555_5555, 1'b0, 1'b1, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA));
    send_frame(make_frame(29'h0AAA_AAAA, 1'b1, 1'b1, 4'd8, 64'h5555_5555_5555_5555));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h0004_0000, 1'b0, 1'b1, 4'd1, 64'h8000_0000_0000_0000));
  endtask

  // Remote frames send no payload whatever the length code says.
  task automatic test_remote_frames();
    send_frame(make_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b1, 1'b0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h0, 1'b1, 1'b0, 4'd0, 64'h0));
    send_frame(make_frame(29'h1234_5678, 1'b1, 1'b0, 4'd9, {$urandom(), $urandom()}));
  endtask

  // Length codes nine to fifteen go out unchanged with eight payload bytes.
  task automatic test_long_length_codes();
    send_frame(make_frame(29'h1ABC_DEF0, 1'b0, 1'b1, 4'd9, {$urandom(), $urandom()}));
    send_frame(make_frame(29'h0765_4321, 1'b1, 1'b1, 4'd12, {$urandom(), $urandom()}));
    send_frame(make_frame(29'h1FFF_FFFF, 1'b0, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(make_frame(29'h0, 1'b1, 1'b1, 4'd15, 64'h0));
  endtask

  // Hold the sender until every queued chunk has come out, then resume.
  task automatic test_drain_pause();
    repeat (4) send_frame(random_frame());
    wait_drained();
    repeat (4) send_frame(random_frame());
  endtask

  task automatic test_random_traffic();
    repeat (155) send_frame(random_frame());
    // Back-to-back frames with the sink always ready.
    sender_steady     = 1'b1;
    sink_always_ready = 1'b1;
    repeat (40) send_frame(random_frame());
    sender_steady     = 1'b0;
    sink_always_ready = 1'b0;
    repeat (40) send_frame(random_frame());
  endtask

  // Sink stalls in runs of random length unless sink_always_ready is set.
  always @(posedge clk_i) begin
    if (sink_always_ready) begin
      out_ready_i <= 1'b1;
    end else if (sink_run == 0) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
      sink_run    <= $urandom_range(1, 30);
    end else begin
      sink_run <= sink_run - 1;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chunks.size() == 0) begin
        $display("%0t: unexpected chunk, expected none got %p", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_chunks.pop_front();
        if (out_data_o.chunk !== want.chunk) begin
          $display("%0t: chunk expected %h got %h", $time, want.chunk, out_data_o.chunk);
          mismatch_count++;
        end
        if (out_data_o.valid_bits !== want.valid_bits) begin
          $display("%0t: valid_bits expected %0d got %0d", $time, want.valid_bits,
                   out_data_o.valid_bits);
          mismatch_count++;
        end
        if (out_data_o.last_chunk !== want.last_chunk) begin
          $display("%0t: last_chunk expected %b got %b", $time, want.last_chunk,
                   out_data_o.last_chunk);
          mismatch_count++;
        end
        if (out_data_o.frame_length !== want.frame_length) begin
          $display("%0t: frame_length expected %0d got %0d", $time, want.frame_length,
                   out_data_o.frame_length);
          mismatch_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_remote_frames();
    test_long_length_codes();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cfs_pkg.sv
design/cfs_crc15.sv
design/cfs_packer.sv
design/can_frame_serializer.sv
dv/tb_can_frame_serializer.sv
